// ===== rtl/core/smeu_pkg.sv =====
// Shared types and constants for the simple machine execute unit.
package smeu_pkg;

    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int NUM_REGS = 16;
    localparam int REG_AW   = 4;

    // Operation codes
    localparam logic [NIB_W-1:0] OP_LOAD_MEM = 4'd1;
    localparam logic [NIB_W-1:0] OP_LOAD_IMM = 4'd2;
    localparam logic [NIB_W-1:0] OP_STORE    = 4'd3;
    localparam logic [NIB_W-1:0] OP_MOVE     = 4'd4;
    localparam logic [NIB_W-1:0] OP_ADD      = 4'd5;
    localparam logic [NIB_W-1:0] OP_JUMP_EQ  = 4'd11;
    localparam logic [NIB_W-1:0] OP_HALT     = 4'd12;

    // Instruction transfer
    typedef struct packed {
        logic [NIB_W-1:0]  opcode;
        logic [REG_AW-1:0] reg_field;
        logic [BYTE_W-1:0] operand;
    } t_in;

    // Result transfer
    typedef struct packed {
        logic [BYTE_W-1:0] pc_value;
        logic              screen_valid;
        logic [BYTE_W-1:0] screen_data;
        logic              jump_taken;
        logic              halted;
        logic              illegal_op;
    } t_out;

endpackage

// ===== rtl/core/simple_machine_execute_unit_top.sv =====
// Top level of the simple machine execute unit.
// Flow: the RAMs are read and the instruction registered at the input transfer edge; execute
//   then writes the result register, after a first phase for a store of a nonzero register.
// Throughput: one instruction per cycle while the result register is free; a store of a nonzero
//   register holds the execute stage for a second phase, since each memory bank takes one write a cycle.
// Reset: synchronous, active low; clears pc, control state and the per-entry valid bits that
//   make register file and memory read as zero until written.
module simple_machine_execute_unit_top #(
    parameter int MEM_DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  smeu_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output smeu_pkg::t_out o_out_data
);

    import smeu_pkg::*;

    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int BANK_DEPTH = MEM_DEPTH / 2;

    // Pipeline registers
    logic              r_x_valid, n_x_valid;
    logic              r_x_phase, n_x_phase;
    t_in               r_x_data;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic              r_out_valid, n_out_valid;
    t_out              r_out_data, n_out_data;

    // Valid bits and last-write forwarding
    logic [NUM_REGS-1:0]  r_rf_valid;
    logic                 r_rf_fwd_valid;
    logic [REG_AW-1:0]    r_rf_fwd_addr;
    logic [BYTE_W-1:0]    r_rf_fwd_data;
    logic [MEM_DEPTH-1:0] r_mem_valid;
    logic [1:0]           r_mfwd_valid;
    logic [ADDR_W-1:0]    r_mfwd_addr [2];
    logic [BYTE_W-1:0]    r_mfwd_data [2];

    logic              in_fire;
    logic [REG_AW-1:0] in_a_addr, in_b_addr;

    logic [NIB_W-1:0]  x_op;
    logic [REG_AW-1:0] x_r, x_hi, x_lo, x_a_addr, x_b_addr;
    logic [BYTE_W-1:0] x_val;
    logic [ADDR_W-1:0] x_maddr, pc_p1;
    logic              x_store_mem, out_free, x_done, x_ib_wr, x_st_wr;

    logic [BYTE_W-1:0] rf_a_q, rf_b_q, rf_a, rf_b;
    logic [BYTE_W-1:0] mem_q [2];
    logic [BYTE_W-1:0] mem_ram, mem_old, mem_rd, ib0;

    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [BYTE_W-1:0] rf_wdata;

    logic [1:0]         bank_we;
    logic [ADDR_W-1:0]  bank_wa [2];
    logic [BYTE_W-1:0]  bank_wd [2];

    logic              jump_taken;

    // Input side: read addresses follow the incoming opcode
    assign in_fire   = i_in_valid && o_in_ready;
    assign in_a_addr = (i_in_data.opcode == OP_ADD) ? i_in_data.operand[7:4]
                                                   : i_in_data.reg_field;
    assign in_b_addr = (i_in_data.opcode == OP_JUMP_EQ) ? REG_AW'(0)
                                                       : i_in_data.operand[3:0];

    // Execute-stage decode
    assign x_op     = r_x_data.opcode;
    assign x_r      = r_x_data.reg_field;
    assign x_val    = r_x_data.operand;
    assign x_hi     = x_val[7:4];
    assign x_lo     = x_val[3:0];
    assign x_maddr  = x_val[ADDR_W-1:0];
    assign x_a_addr = (x_op == OP_ADD) ? x_hi : x_r;
    assign x_b_addr = (x_op == OP_JUMP_EQ) ? REG_AW'(0) : x_lo;
    assign pc_p1    = r_pc + ADDR_W'(1);
    assign ib0      = {x_op, x_r};

    // Handshake and stage control
    assign x_store_mem = (x_op == OP_STORE) && (x_r != REG_AW'(0));
    assign out_free    = !r_out_valid || i_out_ready;
    assign x_done      = r_x_valid && out_free && (!x_store_mem || r_x_phase);
    assign x_ib_wr     = r_x_valid && !r_x_phase && (x_store_mem || x_done);
    assign x_st_wr     = x_done && x_store_mem;
    assign o_in_ready  = !r_x_valid || x_done;

    // Register file: two copies give two read ports
    smeu_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (in_fire),
        .i_raddr (in_a_addr),
        .o_rdata (rf_a_q)
    );

    smeu_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (in_fire),
        .i_raddr (in_b_addr),
        .o_rdata (rf_b_q)
    );

    // Register reads: last write wins, unwritten entries read zero
    always_comb begin
        if (r_rf_fwd_valid && (r_rf_fwd_addr == x_a_addr)) begin
            rf_a = r_rf_fwd_data;
        end else begin
            rf_a = r_rf_valid[x_a_addr] ? rf_a_q : '0;
        end
        if (r_rf_fwd_valid && (r_rf_fwd_addr == x_b_addr)) begin
            rf_b = r_rf_fwd_data;
        end else begin
            rf_b = r_rf_valid[x_b_addr] ? rf_b_q : '0;
        end
    end

    // Main memory: even and odd banks, so pc and pc+1 land in different banks
    for (genvar b = 0; b < 2; b++) begin : g_bank
        smeu_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (bank_wa[b][ADDR_W-1:1]),
            .i_wdata (bank_wd[b]),
            .i_re    (in_fire),
            .i_raddr (i_in_data.operand[ADDR_W-1:1]),
            .o_rdata (mem_q[b])
        );
    end

    // Bank write steering: instruction bytes, else the store byte
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            if (x_ib_wr) begin
                bank_we[b] = 1'b1;
                if (r_pc[0] == 1'(b)) begin
                    bank_wa[b] = r_pc;
                    bank_wd[b] = ib0;
                end else begin
                    bank_wa[b] = pc_p1;
                    bank_wd[b] = x_val;
                end
            end else begin
                bank_we[b] = x_st_wr && (x_maddr[0] == 1'(b));
                bank_wa[b] = x_maddr;
                bank_wd[b] = rf_a;
            end
        end
    end

    // Memory read: own instruction bytes first, then the newest bank write, then the RAM
    always_comb begin
        mem_ram = r_mem_valid[x_maddr] ? mem_q[x_maddr[0]] : '0;
        if (r_mfwd_valid[x_maddr[0]] && (r_mfwd_addr[x_maddr[0]] == x_maddr)) begin
            mem_old = r_mfwd_data[x_maddr[0]];
        end else begin
            mem_old = mem_ram;
        end
        if (x_maddr == r_pc) begin
            mem_rd = ib0;
        end else if (x_maddr == pc_p1) begin
            mem_rd = x_val;
        end else begin
            mem_rd = mem_old;
        end
    end

    // Register write-back
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = x_r;
        rf_wdata = x_val;
        case (x_op)
            OP_LOAD_MEM: begin
                rf_we    = x_done;
                rf_wdata = mem_rd;
            end
            OP_LOAD_IMM: begin
                rf_we    = x_done;
                rf_wdata = x_val;
            end
            OP_MOVE: begin
                rf_we    = x_done;
                rf_waddr = x_hi;
                rf_wdata = rf_b;
            end
            OP_ADD: begin
                rf_we    = x_done;
                rf_wdata = rf_a + rf_b;
            end
            default: begin
                rf_we = 1'b0;
            end
        endcase
    end

    // Result and next state
    assign jump_taken = (x_op == OP_JUMP_EQ) && (rf_a == rf_b);

    always_comb begin
        n_x_valid   = r_x_valid;
        n_x_phase   = r_x_phase;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (x_done) begin
            n_x_phase = 1'b0;
        end else if (x_ib_wr) begin
            n_x_phase = 1'b1;
        end

        if (in_fire) begin
            n_x_valid = 1'b1;
        end else if (x_done) begin
            n_x_valid = 1'b0;
        end

        if (x_done) begin
            n_pc = jump_taken ? x_maddr : (r_pc + ADDR_W'(2));
            n_out_valid             = 1'b1;
            n_out_data.pc_value     = BYTE_W'(n_pc);
            n_out_data.screen_valid = (x_op == OP_STORE) && (x_r == REG_AW'(0));
            n_out_data.screen_data  = n_out_data.screen_valid ? rf_a : '0;
            n_out_data.jump_taken   = jump_taken;
            n_out_data.halted       = (x_op == OP_HALT);
            n_out_data.illegal_op   = !((x_op == OP_LOAD_MEM) || (x_op == OP_LOAD_IMM) ||
                                        (x_op == OP_STORE) || (x_op == OP_MOVE) ||
                                        (x_op == OP_ADD) || (x_op == OP_JUMP_EQ) ||
                                        (x_op == OP_HALT));
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid   <= 1'b0;
            r_x_phase   <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_x_valid   <= n_x_valid;
            r_x_phase   <= n_x_phase;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x_data <= i_in_data;
        end
        r_out_data <= n_out_data;
    end

    // Register file valid bits and last write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid     <= '0;
            r_rf_fwd_valid <= 1'b0;
        end else if (rf_we) begin
            r_rf_valid[rf_waddr] <= 1'b1;
            r_rf_fwd_valid       <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf_fwd_addr <= rf_waddr;
            r_rf_fwd_data <= rf_wdata;
        end
    end

    // Memory valid bits and newest write per bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid  <= '0;
            r_mfwd_valid <= '0;
        end else begin
            for (int b = 0; b < 2; b++) begin
                if (bank_we[b]) begin
                    r_mem_valid[bank_wa[b]] <= 1'b1;
                    r_mfwd_valid[b]         <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 2; b++) begin
            if (bank_we[b]) begin
                r_mfwd_addr[b] <= bank_wa[b];
                r_mfwd_data[b] <= bank_wd[b];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/smeu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module smeu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/simple_machine_execute_unit_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the simple machine execute unit: predicts and checks every result.
module simple_machine_execute_unit_top_tb;
    import smeu_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RST_CYCLES    = 10;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 10;
    localparam int MEM_BYTES     = 256;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    simple_machine_execute_unit_top #(
        .MEM_DEPTH(MEM_BYTES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow machine state and results still owed by the block
    logic [BYTE_W-1:0] reg_img [NUM_REGS];
    logic [BYTE_W-1:0] mem_img [MEM_BYTES];
    logic [BYTE_W-1:0] pc_img;
    t_out              result_q[$];
    t_out              exp_res;
    int                err_count = 0;

    // Sender pacing and receiver stall control
    logic              pace_en     = 1'b0;
    int                burst_left  = 0;
    logic              hold_req    = 1'b0;
    int                hold_left   = 0;
    logic [7:0]        stall_cycle = '0;
    int                idle_cycles = 0;

    function automatic logic is_known_op(input logic [NIB_W-1:0] op);
        case (op)
            OP_LOAD_MEM, OP_LOAD_IMM, OP_STORE, OP_MOVE, OP_ADD, OP_JUMP_EQ, OP_HALT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_in mk(input logic [NIB_W-1:0] op, input logic [REG_AW-1:0] rsel,
                               input logic [BYTE_W-1:0] opnd);
        t_in ins;
        ins.opcode    = op;
        ins.reg_field = rsel;
        ins.operand   = opnd;
        return ins;
    endfunction

    // Execute one instruction on the shadow state; returns the result it must produce
    function automatic t_out exec_instr(input t_in ins);
        t_out              res;
        logic [REG_AW-1:0] hi;
        logic [REG_AW-1:0] lo;
        res = '0;
        hi  = ins.operand[7:4];
        lo  = ins.operand[3:0];
        // instruction bytes land in memory before execution
        mem_img[pc_img] = {ins.opcode, ins.reg_field};
        pc_img          = pc_img + 8'd1;
        mem_img[pc_img] = ins.operand;
        pc_img          = pc_img + 8'd1;
        case (ins.opcode)
            OP_LOAD_MEM: reg_img[ins.reg_field] = mem_img[ins.operand];
            OP_LOAD_IMM: reg_img[ins.reg_field] = ins.operand;
            OP_STORE: begin
                if (ins.reg_field != '0) begin
                    mem_img[ins.operand] = reg_img[ins.reg_field];
                end else begin
                    res.screen_valid = 1'b1;
                    res.screen_data  = reg_img[0];
                end
            end
            OP_MOVE: reg_img[hi] = reg_img[lo];
            OP_ADD:  reg_img[ins.reg_field] = reg_img[hi] + reg_img[lo];
            OP_JUMP_EQ: begin
                if (reg_img[ins.reg_field] == reg_img[0]) begin
                    pc_img         = ins.operand;
                    res.jump_taken = 1'b1;
                end
            end
            OP_HALT: res.halted = 1'b1;
            default: res.illegal_op = 1'b1;
        endcase
        res.pc_value = pc_img;
        return res;
    endfunction

    // Random instruction, weighted toward legal ops that interact with each other
    function automatic t_in random_instr();
        t_in ins;
        int  pick;
        ins  = t_in'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            ins.opcode = OP_LOAD_IMM;
            if ($urandom_range(0, 1) == 0) ins.operand = 8'($urandom_range(0, 3));
        end else if (pick < 30) begin
            ins.opcode = OP_LOAD_MEM;
            if ($urandom_range(0, 3) == 0) ins.operand = pc_img + 8'($urandom_range(0, 1));
        end else if (pick < 45) begin
            ins.opcode = OP_STORE;
            if ($urandom_range(0, 4) == 0) ins.reg_field = '0;
        end else if (pick < 57) begin
            ins.opcode = OP_MOVE;
        end else if (pick < 72) begin
            ins.opcode = OP_ADD;
        end else if (pick < 87) begin
            ins.opcode = OP_JUMP_EQ;
            if ($urandom_range(0, 9) < 3) ins.reg_field = '0;
        end else if (pick < 92) begin
            ins.opcode = OP_HALT;
        end else begin
            while (is_known_op(ins.opcode)) ins.opcode = 4'($urandom_range(0, 15));
        end
        return ins;
    endfunction

    // Offer one instruction, with optional burst gaps, and record its expected result
    task automatic send_instr(input t_in ins);
        int gap;
        if (pace_en && burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= ins;
        do @(posedge i_clk); while (!o_in_ready);
        result_q.push_back(exec_instr(ins));
    endtask

    // Stop offering and wait until every owed result has been checked
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (result_q.size() != 0);
    endtask

    task automatic test_directed();
        pace_en = 1'b0;
        send_instr(mk(OP_LOAD_IMM, 4'd1, 8'hFF));
        send_instr(mk(OP_LOAD_IMM, 4'd15, 8'h80));
        send_instr(mk(OP_ADD, 4'd2, 8'hF1));            // 0x80 + 0xFF wraps
        send_instr(mk(OP_MOVE, 4'd0, 8'h3F));           // R3 = R15
        send_instr(mk(OP_STORE, 4'd2, 8'hFF));
        send_instr(mk(OP_STORE, 4'd15, 8'h00));
        send_instr(mk(OP_LOAD_MEM, 4'd4, 8'hFF));
        // loads that see the instruction's own freshly stored bytes
        send_instr(mk(OP_LOAD_MEM, 4'd5, pc_img));
        send_instr(mk(OP_LOAD_MEM, 4'd6, pc_img + 8'd1));
        // screen output, first with R0 still zero
        send_instr(mk(OP_STORE, 4'd0, 8'h00));
        send_instr(mk(OP_LOAD_IMM, 4'd0, 8'hA5));
        send_instr(mk(OP_STORE, 4'd0, 8'h10));
        // jump not taken, then taken, then taken near the top so the next fetch wraps
        send_instr(mk(OP_JUMP_EQ, 4'd7, 8'h40));
        send_instr(mk(OP_LOAD_IMM, 4'd7, 8'hA5));
        send_instr(mk(OP_JUMP_EQ, 4'd7, 8'h00));
        send_instr(mk(OP_JUMP_EQ, 4'd0, 8'hFE));
        // halt only flags; execution carries on
        send_instr(mk(OP_HALT, 4'd15, 8'hFF));
        send_instr(mk(OP_ADD, 4'd8, 8'h11));
        // every unhandled opcode
        for (int op = 0; op < 16; op++) begin
            if (!is_known_op(4'(op))) begin
                send_instr(mk(4'(op), 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
            end
        end
    endtask

    task automatic test_random(input int count, input logic paced);
        pace_en    = paced;
        burst_left = 0;
        repeat (count) send_instr(random_instr());
    endtask

    // Receiver holds off while the sender keeps offering, so the block fills and stalls
    task automatic test_backpressure(input int count);
        pace_en  = 1'b0;
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (count) send_instr(random_instr());
    endtask

    // Receiver: long hold on request, otherwise a stall pattern chosen by the top bits of a free-running counter
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 8'd1;
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            case (stall_cycle[7:6])
                2'd0: i_out_ready <= 1'b1;
                2'd1: i_out_ready <= 1'($urandom_range(0, 1));
                2'd2: i_out_ready <= (stall_cycle[1:0] == 2'd0);
                default: i_out_ready <= (stall_cycle[1:0] != 2'd0);
            endcase
        end
    end

    task automatic check_field(input string fname, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, fname, exp_v, act_v);
            err_count++;
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %h", $time, o_out_data);
                err_count++;
            end else begin
                exp_res = result_q.pop_front();
                check_field("pc_value", exp_res.pc_value, o_out_data.pc_value);
                check_field("screen_valid", exp_res.screen_valid, o_out_data.screen_valid);
                check_field("screen_data", exp_res.screen_data, o_out_data.screen_data);
                check_field("jump_taken", exp_res.jump_taken, o_out_data.jump_taken);
                check_field("halted", exp_res.halted, o_out_data.halted);
                check_field("illegal_op", exp_res.illegal_op, o_out_data.illegal_op);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("** simple_machine_execute_unit_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (reg_img[i]) reg_img[i] = '0;
        foreach (mem_img[i]) mem_img[i] = '0;
        pc_img = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(300, 1'b1);
        test_random(200, 1'b0);
        wait_drain();
        test_backpressure(40);
        test_random(380, 1'b1);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("** simple_machine_execute_unit_top: PASSED **");
        end else begin
            $display("** simple_machine_execute_unit_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/smeu_pkg.sv
rtl/core/smeu_ram.sv
rtl/core/simple_machine_execute_unit_top.sv
test/simple_machine_execute_unit_top_tb.sv
